// ----- hdl/mbpm_pkg.sv -----
// Package for the masked byte pattern matcher.
// Holds shared constants, register codes, the per-cell flag type and byte helpers.
// No dependencies.
package mbpm_pkg;

    // Default number of cells in the comparator chain.
    localparam int PATTERN_MAX_DEF = 16;

    // Number of pattern bytes held in the configuration registers.
    localparam int PATTERN_REG_BYTES = 16;

    // Width and saturation value of the stream offset.
    localparam int POS_W = 48;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_WILDCARD_MASK  = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_CASE_FOLD      = 3'd4
    } cfg_reg_t;

    // Compare result of one cell of the chain.
    typedef struct packed {
        logic fixed;     // position in use and not a wildcard
        logic mismatch;  // fixed position whose byte differs
        logic short_win; // position in use but no stream byte there yet
    } cell_flags_t;

    // ASCII lower-casing when folding is enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    // Pattern byte k; bytes past the register range read as zero.
    function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input int k);
        logic [127:0] both;
        both = {hi, lo};
        if (k < PATTERN_REG_BYTES) begin
            return both[8*k +: 8];
        end
        return 8'h00;
    endfunction

    // Wildcard flag of pattern byte k; positions past the mask are never wild.
    function automatic logic pat_wild(input logic [15:0] mask, input int k);
        if (k < PATTERN_REG_BYTES) begin
            return mask[k];
        end
        return 1'b0;
    endfunction

endpackage

// ----- hdl/mbpm_cell.sv -----
// One cell of the comparator chain: holds one earlier stream byte and its valid bit.
// Compares the byte it sees against its pattern byte. Depends on mbpm_pkg.
module mbpm_cell
    import mbpm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  logic        clear,
    input  logic [7:0]  byte_in,
    input  logic        valid_in,
    input  logic [7:0]  cmp_byte,
    input  logic        cmp_wild,
    input  logic        in_use,
    input  logic        case_fold,
    output logic [7:0]  byte_out,
    output logic        valid_out,
    output cell_flags_t flags
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    // The byte moves one cell down the chain with every accepted word.
    always_comb begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (shift_en) begin
            byte_next  = byte_in;
            valid_next = valid_in & ~clear;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

    // Local compare of the byte at this distance from the newest byte.
    always_comb begin
        flags.fixed     = in_use & ~cmp_wild;
        flags.mismatch  = in_use & ~cmp_wild &
                          (fold_byte(byte_in, case_fold) != fold_byte(cmp_byte, case_fold));
        flags.short_win = in_use & ~valid_in;
    end

endmodule

// ----- hdl/masked_byte_pattern_matcher.sv -----
// Channel   | Ports                | Word contents
// ----------+----------------------+-----------------------------------------------
// Input     | s_axis_t*            | tdata[7:0] data_byte, tlast last_byte
// Result    | m_axis_t*            | tdata[47:0] match_offset, tuser[0] match_found
// Config    | psel/penable/pwrite  | 64-bit registers at byte address 8*index
//
// One input word is taken every clock unless the result is stalled; its result is
// registered and appears in the cycle after acceptance. The whole compare is one
// pass through the cell chain, so the rate is one byte per cycle. Reset clears the
// chain valid bits, position and shadow counter. A stalled result holds the
// register and the input is accepted again in the cycle the result is taken.
// Top level of the masked byte pattern matcher. Depends on mbpm_pkg and mbpm_cell.
module masked_byte_pattern_matcher
    import mbpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  logic                  s_axis_tlast,  // last_byte
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [POS_W-1:0]      m_axis_tdata,  // [47:0] match_offset
    output logic                  m_axis_tuser,  // [0] match_found
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration registers.
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [15:0]      wild_mask_reg;
    logic [4:0]       pat_len_reg;
    logic             case_fold_reg;
    logic             cfg_wr;
    cfg_reg_t         cfg_idx;

    // Stream state.
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [LEN_W-1:0] blocked_reg;
    logic [LEN_W-1:0] blocked_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             m_found_reg;
    logic             m_found_next;
    logic [POS_W-1:0] m_offset_reg;
    logic [POS_W-1:0] m_offset_next;

    logic             s_acc;
    logic [LEN_W-1:0] len_eff;
    logic             match_hit;

    // Chain wiring.
    logic [7:0]             byte_chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] valid_chain;
    logic [PATTERN_MAX-1:0] fixed_vec;
    logic [PATTERN_MAX-1:0] mis_vec;
    logic [PATTERN_MAX-1:0] short_vec;

    // Register write and read decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            wild_mask_reg <= '0;
            pat_len_reg   <= 5'd1;
            case_fold_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PATTERN_LOW:    pat_low_reg   <= pwdata;
                REG_PATTERN_HIGH:   pat_high_reg  <= pwdata;
                REG_WILDCARD_MASK:  wild_mask_reg <= pwdata[15:0];
                REG_PATTERN_LENGTH: pat_len_reg   <= pwdata[4:0];
                REG_CASE_FOLD:      case_fold_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            REG_WILDCARD_MASK:  prdata = {48'd0, wild_mask_reg};
            REG_PATTERN_LENGTH: prdata = {59'd0, pat_len_reg};
            REG_CASE_FOLD:      prdata = {63'd0, case_fold_reg};
            default:            prdata = '0;
        endcase
    end

    // A length beyond the chain depth uses the whole chain.
    always_comb begin
        if (32'(pat_len_reg) > PATTERN_MAX) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(pat_len_reg);
        end
    end

    // The output register frees the input side whenever it is empty or being drained.
    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign s_acc         = s_axis_tvalid & s_axis_tready;

    // Cell j sees the byte j words back; cell 0 sees the incoming byte.
    assign byte_chain[0]  = s_axis_tdata;
    assign valid_chain[0] = 1'b1;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [LEN_W-1:0] k_sel;
        logic             in_use;
        cell_flags_t      flags;

        // The newest byte lines up with the last used pattern byte.
        assign in_use = LEN_W'(j) < len_eff;
        assign k_sel  = len_eff - LEN_W'(j) - LEN_W'(1);

        if (j < PATTERN_MAX - 1) begin : g_mid
            mbpm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (s_acc),
                .clear     (s_axis_tlast),
                .byte_in   (byte_chain[j]),
                .valid_in  (valid_chain[j]),
                .cmp_byte  (pat_byte(pat_low_reg, pat_high_reg, int'(k_sel))),
                .cmp_wild  (pat_wild(wild_mask_reg, int'(k_sel))),
                .in_use    (in_use),
                .case_fold (case_fold_reg),
                .byte_out  (byte_chain[j+1]),
                .valid_out (valid_chain[j+1]),
                .flags     (flags)
            );
        end else begin : g_end
            // The far end of the chain only compares; its stored byte is never needed.
            mbpm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (s_acc),
                .clear     (s_axis_tlast),
                .byte_in   (byte_chain[j]),
                .valid_in  (valid_chain[j]),
                .cmp_byte  (pat_byte(pat_low_reg, pat_high_reg, int'(k_sel))),
                .cmp_wild  (pat_wild(wild_mask_reg, int'(k_sel))),
                .in_use    (in_use),
                .case_fold (case_fold_reg),
                .byte_out  (),
                .valid_out (),
                .flags     (flags)
            );
        end

        assign fixed_vec[j] = flags.fixed;
        assign mis_vec[j]   = flags.mismatch;
        assign short_vec[j] = flags.short_win;
    end

    // A match needs a full window, at least one fixed position, no mismatch and no shadow.
    assign match_hit = (blocked_reg == '0) & ~(|short_vec) & (|fixed_vec) & ~(|mis_vec);

    // Next position, shadow counter and result.
    always_comb begin
        pos_next      = pos_reg;
        blocked_next  = blocked_reg;
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_offset_next = m_offset_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_acc) begin
            m_valid_next  = 1'b1;
            m_found_next  = match_hit;
            m_offset_next = match_hit ? pos_reg - POS_W'(len_eff - LEN_W'(1)) : '0;
            if (blocked_reg != '0) begin
                blocked_next = blocked_reg - LEN_W'(1);
            end else if (match_hit) begin
                blocked_next = len_eff - LEN_W'(1);
            end
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (s_axis_tlast) begin
                pos_next     = '0;
                blocked_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            blocked_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            blocked_reg <= blocked_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg  <= m_found_next;
        m_offset_reg <= m_offset_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = m_offset_reg;

    // No match may be reported while the previous match's shadow is running.
    a_no_match_in_shadow : assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (blocked_reg != '0) |-> !match_hit)
        else $error("match reported inside the shadow of a previous match");

    // The last byte of a frame returns position and shadow to their start values.
    a_last_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_axis_tlast |=> (pos_reg == '0) && (blocked_reg == '0))
        else $error("stream state not cleared after the last byte");

    // A match loads the shadow with the pattern length less one.
    a_shadow_load : assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && match_hit && !s_axis_tlast |=>
        blocked_reg == $past(len_eff - LEN_W'(1)))
        else $error("shadow counter not loaded after a match");

    // A result without a match carries a zero offset.
    a_zero_offset : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_offset_reg == '0)
        else $error("nonzero offset on a word without a match");

endmodule

// ----- tb/sv/mbpm_result_check.sv -----
// Result checker for the masked byte pattern matcher testbench.
// Watches the input, result and register channels, predicts every result word and
// compares it with the block's output. Depends on mbpm_pkg.
module mbpm_result_check
    import mbpm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  logic                  s_axis_tlast,  // last_byte
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [POS_W-1:0]      m_axis_tdata,  // [47:0] match_offset
    input  logic                  m_axis_tuser,  // [0] match_found
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending_words
);

    localparam int DEPTH = PATTERN_MAX_DEF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] offset;
    } match_word_t;

    // Register copies, updated from observed writes.
    logic [63:0] pat_lo_q;
    logic [63:0] pat_hi_q;
    logic [15:0] wild_q;
    logic [4:0]  len_q;
    logic        fold_q;

    // Stream state: previous bytes (newest at index 0), offset and match shadow.
    logic [7:0]       hist_q [DEPTH-1];
    logic [POS_W-1:0] pos_q;
    logic [4:0]       shadow_q;

    match_word_t expected_matches[$];
    int          bad_words;
    int          word_index;

    function automatic logic [7:0] lower_ascii(input logic [7:0] b, input logic en);
        if (en && b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    task automatic clear_stream();
        for (int i = 0; i < DEPTH - 1; i++) begin
            hist_q[i] = 8'h00;
        end
        pos_q    = '0;
        shadow_q = '0;
    endtask

    // Predict the result word for one accepted byte and advance the stream state.
    task automatic scan_byte(input logic [7:0] b, input logic last);
        int           eff;
        logic         any_fixed;
        logic         all_equal;
        logic [7:0]   seen;
        logic [127:0] pat;
        match_word_t  res;
        eff       = (len_q > DEPTH) ? DEPTH : int'(len_q);
        pat       = {pat_hi_q, pat_lo_q};
        res       = '0;
        any_fixed = 1'b0;
        all_equal = 1'b1;
        if (shadow_q != 0) begin
            shadow_q = shadow_q - 5'd1;
        end else if (eff > 0 && pos_q >= POS_W'(eff - 1)) begin
            for (int k = 0; k < eff; k++) begin
                if (!wild_q[k]) begin
                    any_fixed = 1'b1;
                    seen = (k == eff - 1) ? b : hist_q[eff - 2 - k];
                    if (lower_ascii(seen, fold_q) != lower_ascii(pat[8*k +: 8], fold_q)) begin
                        all_equal = 1'b0;
                    end
                end
            end
            if (any_fixed && all_equal) begin
                res.found  = 1'b1;
                res.offset = pos_q - POS_W'(eff - 1);
                shadow_q   = 5'(eff - 1);
            end
        end
        for (int i = DEPTH - 2; i > 0; i--) begin
            hist_q[i] = hist_q[i-1];
        end
        hist_q[0] = b;
        if (pos_q != POS_MAX) begin
            pos_q = pos_q + POS_W'(1);
        end
        if (last) begin
            clear_stream();
        end
        expected_matches.insert(expected_matches.size(), res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_q   = '0;
            pat_hi_q   = '0;
            wild_q     = '0;
            len_q      = 5'd1;
            fold_q     = 1'b0;
            clear_stream();
            expected_matches.delete();
            bad_words  = 0;
            word_index = 0;
        end else begin
            // Results are registered and leave after their byte, so compare before predicting.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_matches.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display({"ERROR: result word %0d arrived with none expected: ",
                                  "found=%0b offset=%0d"},
                                 word_index, m_axis_tuser, m_axis_tdata);
                    end
                end else begin
                    match_word_t want;
                    want = expected_matches.pop_front();
                    if (m_axis_tuser !== want.found || m_axis_tdata !== want.offset) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display({"ERROR: result word %0d: expected found=%0b ",
                                      "offset=%0d, got found=%0b offset=%0d"},
                                     word_index, want.found, want.offset,
                                     m_axis_tuser, m_axis_tdata);
                        end
                    end
                end
                word_index++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
            end
            // A register write takes effect from the next byte on.
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[CFG_IDX_LSB +: CFG_IDX_W]))
                    REG_PATTERN_LOW:    pat_lo_q = pwdata;
                    REG_PATTERN_HIGH:   pat_hi_q = pwdata;
                    REG_WILDCARD_MASK:  wild_q   = pwdata[15:0];
                    REG_PATTERN_LENGTH: len_q    = pwdata[4:0];
                    REG_CASE_FOLD:      fold_q   = pwdata[0];
                    default: ;
                endcase
            end
        end
        fail_count    <= bad_words;
        pending_words <= expected_matches.size();
    end

endmodule

// ----- tb/sv/tb_masked_byte_pattern_matcher.sv -----
// Top of the masked byte pattern matcher testbench: clock, reset, stimulus and verdict.
// Depends on mbpm_pkg, masked_byte_pattern_matcher and mbpm_result_check.
module tb_masked_byte_pattern_matcher;
    import mbpm_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 24;
    localparam int WORDS_PER_PHASE = 75;
    localparam int HOLD_CYCLES     = 250;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] data_byte
    logic                  s_axis_tlast;   // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [POS_W-1:0]      m_axis_tdata;   // [47:0] match_offset
    logic                  m_axis_tuser;   // [0] match_found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_words;
    int cycle_count;
    int words_sent;
    bit gaps_on;
    bit long_hold;
    bit hold_done;

    // Current register settings, used to shape the byte stream.
    logic [127:0] cur_pat;
    logic [15:0]  cur_wild;
    logic [4:0]   cur_len;

    masked_byte_pattern_matcher u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mbpm_result_check u_result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        forever begin
            if (long_hold && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one word and return at the edge that accepts it; valid stays high.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input cfg_reg_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers are only written with the block idle.
    task automatic apply_config(input logic [127:0] pat, input logic [15:0] mask,
                                input logic [4:0] len, input logic fold);
        drain_words();
        apb_write(REG_PATTERN_LOW, pat[63:0]);
        apb_write(REG_PATTERN_HIGH, pat[127:64]);
        apb_write(REG_WILDCARD_MASK, {48'h0, mask});
        apb_write(REG_PATTERN_LENGTH, {59'h0, len});
        apb_write(REG_CASE_FOLD, {63'h0, fold});
        cur_pat  = pat;
        cur_wild = mask;
        cur_len  = len;
    endtask

    // Noise byte: full range, a pattern byte, or a byte at the edges of the letter ranges.
    function automatic logic [7:0] rand_byte();
        int idx;
        idx = $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0: return cur_pat[8*idx +: 8];
            1: begin
                case ($urandom_range(0, 7))
                    0: return 8'h40;
                    1: return 8'h41;
                    2: return 8'h5A;
                    3: return 8'h5B;
                    4: return 8'h60;
                    5: return 8'h61;
                    6: return 8'h7A;
                    default: return 8'h7B;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one copy of the pattern: random bytes at wildcards, letters sometimes in the
    // other case, and now and then one position spoiled.
    task automatic emit_copy();
        int         eff;
        int         spoil;
        logic [7:0] b;
        eff   = (cur_len == 0) ? 1 : ((cur_len > 16) ? 16 : int'(cur_len));
        spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : -1;
        for (int k = 0; k < eff; k++) begin
            if (k == spoil || cur_wild[k]) begin
                b = rand_byte();
            end else begin
                b = cur_pat[8*k +: 8];
                if ($urandom_range(0, 1) == 1 &&
                    ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
                    b = b ^ 8'h20;
                end
            end
            push_byte(b, 1'b0);
        end
    endtask

    task automatic random_config(input int phase);
        logic [127:0] pat;
        logic [15:0]  mask;
        logic [4:0]   len;
        logic         fold;
        int           pick;
        // Mostly a few letters in either case, so near misses and overlaps are common.
        for (int k = 0; k < 16; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                pat[8*k +: 8] = 8'($urandom_range(0, 255));
            end else begin
                pat[8*k +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 3));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            mask = 16'h0000;
        end else if (pick == 4) begin
            mask = 16'hFFFF;
        end else if (pick < 8) begin
            mask = 16'($urandom) & 16'($urandom);
        end else begin
            mask = 16'($urandom);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            len = 5'd0;
        end else if (pick == 1) begin
            len = 5'd16;
        end else if (pick == 2) begin
            len = 5'($urandom_range(17, 31));
        end else if (pick == 3) begin
            len = 5'($urandom_range(9, 15));
        end else begin
            len = 5'($urandom_range(1, 8));
        end
        fold = 1'($urandom_range(0, 1));
        // A couple of fixed extreme settings.
        if (phase == 1) begin
            pat  = '1;
            mask = 16'h0000;
            len  = 5'd16;
        end else if (phase == 2) begin
            pat  = '0;
            mask = 16'hFFFB;
            len  = 5'd31;
        end
        apply_config(pat, mask, len, fold);
    endtask

    initial begin
        int phase_end;
        int pick;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        gaps_on    = 1'b1;
        long_hold  = 1'b0;
        words_sent = 0;
        cur_pat    = '0;
        cur_wild   = '0;
        cur_len    = 5'd1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-byte pattern 0x00.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        // Zero length never matches.
        apply_config(128'h0, 16'h0000, 5'd0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);

        // Folded "aa": matches must not overlap.
        apply_config(128'h6161, 16'h0000, 5'd2, 1'b1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b1);

        // All positions wild never matches.
        apply_config(128'h0, 16'hFFFF, 5'd2, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);

        // Oversized length acts as 16; no match until the window is full.
        apply_config('1, 16'h8001, 5'd31, 1'b0);
        push_byte(8'h00, 1'b0);
        repeat (14) push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b1);

        // Random phases, each with fresh settings over a continuing stream.
        for (int phase = 0; phase < PHASES; phase++) begin
            random_config(phase);
            if (phase == 4) begin
                long_hold = 1'b1;
            end
            if (phase >= PHASES - 3) begin
                gaps_on = 1'b0;
            end
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    emit_copy();
                end else if (pick < 19) begin
                    repeat ($urandom_range(1, 4)) push_byte(rand_byte(), 1'b0);
                end else begin
                    push_byte(rand_byte(), 1'b1);
                end
            end
        end

        drain_words();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
